// File: src/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg
// Shared constants, codes and controller/datapath interface types for the
// 32-bit-per-pixel framebuffer drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fde_pkg;

    // Store geometry.
    localparam int FRAME_PIXELS   = 65536;
    localparam int PIX_AW         = $clog2(FRAME_PIXELS);
    localparam int GLYPH_ROWS_MAX = 16;
    localparam int GLYPH_COUNT    = 256;
    localparam int GROW_W         = $clog2(GLYPH_ROWS_MAX);
    localparam int GLYPH_CELLS    = GLYPH_COUNT * GLYPH_ROWS_MAX;
    localparam int GLYPH_AW       = $clog2(GLYPH_CELLS);

    // Datapath widths. A coordinate holds a 12-bit field plus a glyph offset.
    localparam int COORD_W  = 13;
    localparam int STRIDE_W = 13;
    localparam int BASE_W   = COORD_W + STRIDE_W;
    localparam int ADDR_W   = BASE_W + 1;
    localparam int PCNT_W   = 5;
    localparam int CFG_DW   = 13;
    localparam int CFG_IW   = 2;

    // Glyph and color constants.
    localparam int GLYPH_BITS      = 8;
    localparam int TRANSPARENT_BIT = 31;

    // Register reset values.
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd256;
    localparam logic [4:0]          FWIDTH_RESET = 5'd8;
    localparam logic [4:0]          FHEIGHT_RESET = 5'd16;

    // Command codes.
    localparam logic [2:0] CMD_PUT   = 3'd0;
    localparam logic [2:0] CMD_GET   = 3'd1;
    localparam logic [2:0] CMD_HLINE = 3'd2;
    localparam logic [2:0] CMD_CHAR  = 3'd3;
    localparam logic [2:0] CMD_FONT  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_STRIDE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MODE    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FWIDTH  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_FHEIGHT = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_ROW,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic clear_step;
        logic glyph_wr;
        logic row_start;
        logic addr_calc;
        logic pix_read;
        logic pix_write;
        logic next_col;
        logic next_row;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clear_last;
        logic [2:0] cmd;
        logic       invert;
        logic       char_empty;
        logic       col_last;
        logic       row_last;
        logic       out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/framebuffer_draw_engine_32bpp.sv
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_32bpp
// 32-bit-per-pixel framebuffer drawing engine with a linear pixel store
// and a glyph font store.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (in_valid/in_stall) and are taken one
// at a time; in_stall stays high while a command is in progress. Get pixel
// produces one result on the output channel (out_valid/out_stall); no other
// command produces a result. Registers are written on the cfg channel, which
// is always ready; the user must write them only while the engine is idle,
// as the block itself does not enforce it. Put char draws width pixels on
// each of rows rows, where rows is the font height capped at 16; it draws
// nothing when width or height is zero.
// Each pixel takes an address step and a write step on the single pixel
// store port, plus a read step for inversion in put and hline; each glyph row
// takes a multiply step for the row base address.
// After reset both stores are cleared one word per cycle; in_stall is high
// throughout. A stalled result waits in the output register; the engine
// keeps accepting commands and holds a second get pixel in its response
// step until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_draw_engine_32bpp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [2:0]                         cmd,
    input  wire logic [11:0]                        x,
    input  wire logic [11:0]                        x_end,
    input  wire logic [11:0]                        y,
    input  wire logic [31:0]                        color,
    input  wire logic [31:0]                        back_color,
    input  wire logic [7:0]                         char_code,
    input  wire logic [fde_pkg::GROW_W-1:0]         glyph_row,
    input  wire logic [fde_pkg::GLYPH_BITS-1:0]     glyph_bits,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [31:0]                             pixel_value,
    output logic                                    out_of_range,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fde_pkg::CFG_IW-1:0]         cfg_index,
    input  wire logic [fde_pkg::CFG_DW-1:0]         cfg_data
);

    fde_pkg::ctrl_cmd_t  ctrl_cmd;
    fde_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    // Command sequencer.
    fde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (dp_status),
        .cmd      (ctrl_cmd)
    );

    // Stores and arithmetic.
    fde_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .st           (dp_status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_in       (cmd),
        .x            (x),
        .x_end        (x_end),
        .y            (y),
        .color        (color),
        .back_color   (back_color),
        .char_code    (char_code),
        .glyph_row    (glyph_row),
        .glyph_bits   (glyph_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_value  (pixel_value),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

// File: src/fde_ctrl.sv
// ----------------------------------------------------------------------------
// fde_ctrl
// Command sequencer: clears the stores after reset, then steps each pixel
// command through row setup, address, optional read, and write or response.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire fde_pkg::dp_status_t st,
    output fde_pkg::ctrl_cmd_t       cmd
);

    fde_pkg::state_t state_reg;
    fde_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fde_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != fde_pkg::ST_IDLE);

        case (state_reg)
            fde_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_last)
                begin
                    state_next = fde_pkg::ST_IDLE;
                end
            end

            fde_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = fde_pkg::ST_DISPATCH;
                end
            end

            fde_pkg::ST_DISPATCH:
            begin
                case (st.cmd)
                    fde_pkg::CMD_PUT, fde_pkg::CMD_GET, fde_pkg::CMD_HLINE:
                    begin
                        state_next = fde_pkg::ST_ROW;
                    end
                    fde_pkg::CMD_CHAR:
                    begin
                        state_next = st.char_empty ? fde_pkg::ST_IDLE : fde_pkg::ST_ROW;
                    end
                    fde_pkg::CMD_FONT:
                    begin
                        cmd.glyph_wr = 1'b1;
                        state_next   = fde_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = fde_pkg::ST_IDLE;
                    end
                endcase
            end

            fde_pkg::ST_ROW:
            begin
                cmd.row_start = 1'b1;
                state_next    = fde_pkg::ST_ADDR;
            end

            fde_pkg::ST_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                if (st.cmd == fde_pkg::CMD_GET
                    || (st.invert && st.cmd != fde_pkg::CMD_CHAR))
                begin
                    state_next = fde_pkg::ST_READ;
                end
                else
                begin
                    state_next = fde_pkg::ST_WRITE;
                end
            end

            fde_pkg::ST_READ:
            begin
                cmd.pix_read = 1'b1;
                state_next   = (st.cmd == fde_pkg::CMD_GET) ? fde_pkg::ST_RESP
                                                            : fde_pkg::ST_WRITE;
            end

            fde_pkg::ST_WRITE:
            begin
                cmd.pix_write = 1'b1;
                if (st.cmd == fde_pkg::CMD_PUT)
                begin
                    state_next = fde_pkg::ST_IDLE;
                end
                else if (!st.col_last)
                begin
                    cmd.next_col = 1'b1;
                    state_next   = fde_pkg::ST_ADDR;
                end
                else if (st.cmd == fde_pkg::CMD_CHAR && !st.row_last)
                begin
                    cmd.next_row = 1'b1;
                    state_next   = fde_pkg::ST_ROW;
                end
                else
                begin
                    state_next = fde_pkg::ST_IDLE;
                end
            end

            fde_pkg::ST_RESP:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fde_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fde_pkg::ST_IDLE;
            end
        endcase
    end

    // Items are taken only when idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |=> state_reg == fde_pkg::ST_DISPATCH)
        else $error("accepted item did not reach dispatch");

    // No drawing or response activity while the stores are being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fde_pkg::ST_CLEAR) |-> !(cmd.pix_write || cmd.out_load || cmd.latch_in))
        else $error("command issued during store clear");

endmodule

`default_nettype wire

// File: src/fde_datapath.sv
// ----------------------------------------------------------------------------
// fde_datapath
// Configuration registers, pixel and glyph stores, address arithmetic,
// glyph bit expansion and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire fde_pkg::ctrl_cmd_t                 cmd,
    output fde_pkg::dp_status_t                     st,
    input  wire logic                               cfg_valid,
    input  wire logic [fde_pkg::CFG_IW-1:0]         cfg_index,
    input  wire logic [fde_pkg::CFG_DW-1:0]         cfg_data,
    input  wire logic [2:0]                         cmd_in,
    input  wire logic [11:0]                        x,
    input  wire logic [11:0]                        x_end,
    input  wire logic [11:0]                        y,
    input  wire logic [31:0]                        color,
    input  wire logic [31:0]                        back_color,
    input  wire logic [7:0]                         char_code,
    input  wire logic [fde_pkg::GROW_W-1:0]         glyph_row,
    input  wire logic [fde_pkg::GLYPH_BITS-1:0]     glyph_bits,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [31:0]                             pixel_value,
    output logic                                    out_of_range
);

    // Configuration registers.
    logic [fde_pkg::STRIDE_W-1:0] stride_reg;
    logic                         mode_reg;
    logic [4:0]                   fwidth_reg;
    logic [4:0]                   fheight_reg;

    // Latched command fields.
    logic [2:0]                      cmd_reg;
    logic [11:0]                     x_reg;
    logic [11:0]                     hi_reg;
    logic [31:0]                     color_reg;
    logic [31:0]                     back_reg;
    logic [7:0]                      char_reg;
    logic [fde_pkg::GROW_W-1:0]      grow_reg;
    logic [fde_pkg::GLYPH_BITS-1:0]  gbits_reg;

    // Walk state.
    logic [fde_pkg::COORD_W-1:0]     col_reg;
    logic [fde_pkg::COORD_W-1:0]     row_y_reg;
    logic [fde_pkg::GROW_W-1:0]      row_reg;
    logic [fde_pkg::PCNT_W-1:0]      p_reg;
    logic [fde_pkg::BASE_W-1:0]      base_reg;
    logic [fde_pkg::ADDR_W-1:0]      addr_reg;
    logic [fde_pkg::PIX_AW-1:0]      clear_cnt_reg;

    // Stores and their registered read data.
    logic [31:0]                     pix_mem [fde_pkg::FRAME_PIXELS];
    logic [fde_pkg::GLYPH_BITS-1:0]  glyph_mem [fde_pkg::GLYPH_CELLS];
    logic [31:0]                     pix_rdata_reg;
    logic [fde_pkg::GLYPH_BITS-1:0]  glyph_rdata_reg;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] pixel_value_reg;
    logic        out_of_range_reg;

    logic                             in_range;
    logic                             bit_set;
    logic                             transparent;
    logic [fde_pkg::GROW_W-1:0]       rows_last;
    logic [2:0]                       bit_sel;
    logic                             pix_we;
    logic [fde_pkg::PIX_AW-1:0]       pix_waddr;
    logic [31:0]                      pix_wdata;
    logic                             glyph_we;
    logic [fde_pkg::GLYPH_AW-1:0]     glyph_waddr;
    logic [fde_pkg::GLYPH_BITS-1:0]   glyph_wdata;
    logic                             glyph_clear_en;

    // Configuration writes; the port is always ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg  <= fde_pkg::STRIDE_RESET;
            mode_reg    <= 1'b0;
            fwidth_reg  <= fde_pkg::FWIDTH_RESET;
            fheight_reg <= fde_pkg::FHEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fde_pkg::CFG_STRIDE:  stride_reg  <= cfg_data;
                fde_pkg::CFG_MODE:    mode_reg    <= cfg_data[0];
                fde_pkg::CFG_FWIDTH:  fwidth_reg  <= cfg_data[4:0];
                fde_pkg::CFG_FHEIGHT: fheight_reg <= cfg_data[4:0];
                default:              ;
            endcase
        end
    end

    // Command field capture. Hline starts at the lower column.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg   <= cmd_in;
            x_reg     <= x;
            hi_reg    <= (x < x_end) ? x_end : x;
            color_reg <= color;
            back_reg  <= back_color;
            char_reg  <= char_code;
            grow_reg  <= glyph_row;
            gbits_reg <= glyph_bits;
        end
    end

    // Column, row and address walk.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            col_reg   <= {1'b0, ((cmd_in == fde_pkg::CMD_HLINE && x_end < x) ? x_end : x)};
            row_y_reg <= {1'b0, y};
            row_reg   <= '0;
            p_reg     <= '0;
        end
        else if (cmd.next_col)
        begin
            col_reg <= col_reg + 1'b1;
            p_reg   <= p_reg + 1'b1;
        end
        else if (cmd.next_row)
        begin
            col_reg   <= {1'b0, x_reg};
            row_y_reg <= row_y_reg + 1'b1;
            row_reg   <= row_reg + 1'b1;
            p_reg     <= '0;
        end

        if (cmd.row_start)
        begin
            base_reg <= fde_pkg::BASE_W'(row_y_reg) * fde_pkg::BASE_W'(stride_reg);
        end
        if (cmd.addr_calc)
        begin
            addr_reg <= fde_pkg::ADDR_W'(base_reg)
                        + fde_pkg::ADDR_W'(col_reg);
        end
    end

    // Clear counter, stepped once per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Per-pixel decisions.
    assign in_range    = (addr_reg < fde_pkg::ADDR_W'(fde_pkg::FRAME_PIXELS));
    assign bit_sel     = 3'(fde_pkg::GLYPH_BITS - 1) - p_reg[2:0];
    assign bit_set     = (p_reg < fde_pkg::PCNT_W'(fde_pkg::GLYPH_BITS))
                         && glyph_rdata_reg[bit_sel];
    assign transparent = back_reg[fde_pkg::TRANSPARENT_BIT];
    assign rows_last   = (fheight_reg > 5'(fde_pkg::GLYPH_ROWS_MAX))
                         ? fde_pkg::GROW_W'(fde_pkg::GLYPH_ROWS_MAX - 1)
                         : fde_pkg::GROW_W'(fheight_reg - 5'd1);

    // Pixel store write port: clear sweep or drawing.
    always_comb
    begin
        if (cmd.clear_step)
        begin
            pix_we    = 1'b1;
            pix_waddr = clear_cnt_reg;
            pix_wdata = '0;
        end
        else
        begin
            pix_waddr = addr_reg[fde_pkg::PIX_AW-1:0];
            if (cmd_reg == fde_pkg::CMD_CHAR)
            begin
                pix_we    = cmd.pix_write && in_range && (bit_set || !transparent);
                pix_wdata = bit_set ? color_reg : back_reg;
            end
            else
            begin
                pix_we    = cmd.pix_write && in_range;
                pix_wdata = mode_reg ? ~pix_rdata_reg : color_reg;
            end
        end
    end

    // Glyph store write port: clear sweep or font row load.
    assign glyph_clear_en = (clear_cnt_reg < fde_pkg::PIX_AW'(fde_pkg::GLYPH_CELLS));
    always_comb
    begin
        if (cmd.clear_step)
        begin
            glyph_we    = glyph_clear_en;
            glyph_waddr = clear_cnt_reg[fde_pkg::GLYPH_AW-1:0];
            glyph_wdata = '0;
        end
        else
        begin
            glyph_we    = cmd.glyph_wr;
            glyph_waddr = {char_reg, grow_reg};
            glyph_wdata = gbits_reg;
        end
    end

    // Pixel store.
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (cmd.pix_read)
        begin
            pix_rdata_reg <= pix_mem[addr_reg[fde_pkg::PIX_AW-1:0]];
        end
    end

    // Glyph store; a row is read once at the start of each glyph row.
    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_mem[glyph_waddr] <= glyph_wdata;
        end
        if (cmd.row_start)
        begin
            glyph_rdata_reg <= glyph_mem[{char_reg, row_reg}];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_value_reg  <= in_range ? pix_rdata_reg : '0;
            out_of_range_reg <= !in_range;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_value  = pixel_value_reg;
    assign out_of_range = out_of_range_reg;

    // Status to the controller.
    always_comb
    begin
        st            = '0;
        st.clear_last = &clear_cnt_reg;
        st.cmd        = cmd_reg;
        st.invert     = mode_reg;
        st.char_empty = (fwidth_reg == '0) || (fheight_reg == '0);
        st.col_last   = (cmd_reg == fde_pkg::CMD_CHAR)
                        ? (p_reg == fwidth_reg - 5'd1)
                        : (col_reg == {1'b0, hi_reg});
        st.row_last   = (row_reg == rows_last);
        st.out_busy   = out_valid_reg && out_stall;
    end

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    // An out-of-range read always returns zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_of_range_reg) |-> (pixel_value_reg == '0))
        else $error("out-of-range read returned nonzero data");

    // At most one datapath step per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_step, cmd.row_start, cmd.addr_calc,
                  cmd.pix_read, cmd.pix_write, cmd.out_load}))
        else $error("conflicting datapath commands");

    // Glyph row data holds while its pixels are drawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pix_write && cmd_reg == fde_pkg::CMD_CHAR) |-> $stable(glyph_rdata_reg))
        else $error("glyph row changed during expansion");

endmodule

`default_nettype wire
